/* sv/cfq_pkg.sv */
// Shared types and constants for the circular FIFO queue.
package cfq_pkg;

    localparam int CAP_W     = 4;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int CAP_RESET = 8;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic               func;
        logic signed [31:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] pop_value;
        logic               is_full;
        logic               is_empty;
    } out_item_t;

endpackage

/* sv/cfq_cell.sv */
// One storage cell of the ring: holds a word and forwards the read chain.
module cfq_cell
    import cfq_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 3
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [IW-1:0]     wr_idx,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [IW-1:0]     rd_idx,
    input  logic [WORD_W-1:0] rd_chain_in,
    output logic [WORD_W-1:0] rd_chain_out
);

    logic [WORD_W-1:0] word_reg;
    logic              hit_wr;
    logic              hit_rd;

    assign hit_wr = wr_en && (wr_idx == IW'(IDX));
    assign hit_rd = (rd_idx == IW'(IDX));

    always_ff @(posedge aclk) begin
        if (hit_wr) begin
            word_reg <= wr_data;
        end
    end

    // pass the neighbor's word unless this cell is the one addressed
    assign rd_chain_out = hit_rd ? word_reg : rd_chain_in;

endmodule

/* sv/circular_fifo_queue.sv */
// Circular FIFO queue: index control, capacity register and a row of storage cells.
// The result of an accepted request is registered in the output register and appears in the cycle after acceptance.
// Throughput: one request per cycle while m_ready is high; the output register
// frees s_ready as soon as the pending result is taken.
// The dequeued word is picked out by a read chain running through all DEPTH cells.
// Reset (aresetn low, synchronous): head and tail go to zero, the queue is empty,
// cap_reg returns to 8; the cell contents are not cleared.
module circular_fifo_queue
    import cfq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW = ((IW > CAP_W) ? IW : CAP_W) + 1;

    logic [CAP_W-1:0] cap_reg;
    logic [IW-1:0]    head_reg, head_next;
    logic [IW-1:0]    tail_reg, tail_next;
    logic             empty_reg, empty_next;
    logic             out_valid_reg;
    out_item_t        out_reg, out_next;

    logic             accept;
    logic             cfg_wr;
    logic [CMPW-1:0]  cap_eff;
    logic [CMPW-1:0]  cap_m1;
    logic [IW-1:0]    tail_adv;
    logic [IW-1:0]    head_adv;
    logic             full_now;
    logic             wr_en;
    logic [IW-1:0]    wr_idx;
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] chain [DEPTH+1];

    function automatic logic [IW-1:0] advance(input logic [IW-1:0] x,
                                              input logic [CMPW-1:0] lim);
        logic [IW-1:0] r;
        if (CMPW'(x) >= lim) begin
            r = '0;
        end else begin
            r = x + IW'(1);
        end
        return r;
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {{(32-CAP_W){1'b0}}, cap_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_W'(CAP_RESET);
        end else if (cfg_wr) begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // clamp capacity to 1..DEPTH
    always_comb begin
        cap_eff = CMPW'(cap_reg);
        if (cap_eff == '0) begin
            cap_eff = CMPW'(1);
        end
        if (cap_eff > CMPW'(DEPTH)) begin
            cap_eff = CMPW'(DEPTH);
        end
    end
    assign cap_m1 = cap_eff - CMPW'(1);

    assign tail_adv = advance(tail_reg, cap_m1);
    assign head_adv = advance(head_reg, cap_m1);
    assign full_now = !empty_reg && (tail_adv == head_reg);

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // storage row
    assign chain[0] = '0;
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        cfq_cell #(
            .IDX(i),
            .IW (IW)
        ) u_cell (
            .aclk        (aclk),
            .wr_en       (wr_en),
            .wr_idx      (wr_idx),
            .wr_data     (s_data.push_value),
            .rd_idx      (head_reg),
            .rd_chain_in (chain[i]),
            .rd_chain_out(chain[i+1])
        );
    end
    assign rd_word = chain[DEPTH];

    always_comb begin
        head_next          = head_reg;
        tail_next          = tail_reg;
        empty_next         = empty_reg;
        wr_en              = 1'b0;
        wr_idx             = tail_adv;
        out_next.status    = ST_DONE;
        out_next.pop_value = '0;
        if (accept) begin
            if (s_data.func == OP_ENQUEUE) begin
                if (full_now) begin
                    out_next.status = ST_FULL;
                end else if (empty_reg) begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                    wr_en      = 1'b1;
                    wr_idx     = '0;
                end else begin
                    tail_next = tail_adv;
                    wr_en     = 1'b1;
                end
            end else begin
                if (empty_reg) begin
                    out_next.status    = ST_EMPTY;
                    out_next.pop_value = '1;
                end else begin
                    out_next.pop_value = rd_word;
                    if (head_reg == tail_reg) begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b1;
                    end else begin
                        head_next = head_adv;
                    end
                end
            end
        end
        out_next.is_full  = !empty_next && (advance(tail_next, cap_m1) == head_next);
        out_next.is_empty = empty_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_empty_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        empty_reg |-> (head_reg == '0) && (tail_reg == '0))
        else $error("empty queue with nonzero index");

    a_full_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.is_full && m_data.is_empty))
        else $error("result flags full and empty together");

    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_data.func == OP_ENQUEUE) && full_now
        |=> $stable(head_reg) && $stable(tail_reg) && $stable(empty_reg))
        else $error("rejected enqueue moved the indices");

    a_result_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted request produced no result");

endmodule

/* dv/tb_top.sv */
// Testbench for circular_fifo_queue: directed table, random push/pop phases, scoreboard.
`timescale 1ns / 100ps

module tb_top;
    import cfq_pkg::*;

    localparam int DEPTH        = 8;
    localparam logic [2:0] CAP_ADDR = 3'd0;
    localparam int REQUEST_GOAL = 1050;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_LEN     = 64;
    localparam int NUM_DIRECTED = 27;

    typedef enum logic { ROW_REQUEST, ROW_CAPACITY } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        op_t         op;
        logic [31:0] word;   // push value, or capacity for a register row
        logic        typed;  // use the result written in the row
        out_item_t   want;
    } dir_row_t;

    localparam out_item_t NO_RESULT = '0;

    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        '{ROW_REQUEST,  OP_DEQUEUE, 32'h0000_0000, 1'b1, '{ST_EMPTY, 32'hFFFF_FFFF, 1'b0, 1'b1}},
        '{ROW_REQUEST,  OP_ENQUEUE, 32'h7FFF_FFFF, 1'b1, '{ST_DONE,  32'h0000_0000, 1'b0, 1'b0}},
        '{ROW_REQUEST,  OP_ENQUEUE, 32'h8000_0000, 1'b1, '{ST_DONE,  32'h0000_0000, 1'b0, 1'b0}},
        '{ROW_REQUEST,  OP_DEQUEUE, 32'h0000_0000, 1'b1, '{ST_DONE,  32'h7FFF_FFFF, 1'b0, 1'b0}},
        '{ROW_REQUEST,  OP_DEQUEUE, 32'h0000_0000, 1'b1, '{ST_DONE,  32'h8000_0000, 1'b0, 1'b1}},
        '{ROW_CAPACITY, OP_ENQUEUE, 32'd1,         1'b0, NO_RESULT},
        '{ROW_REQUEST,  OP_ENQUEUE, 32'h0000_0000, 1'b1, '{ST_DONE,  32'h0000_0000, 1'b1, 1'b0}},
        '{ROW_REQUEST,  OP_ENQUEUE, 32'hFFFF_FFFF, 1'b1, '{ST_FULL,  32'h0000_0000, 1'b1, 1'b0}},
        '{ROW_REQUEST,  OP_DEQUEUE, 32'h0000_0000, 1'b1, '{ST_DONE,  32'h0000_0000, 1'b0, 1'b1}},
        '{ROW_CAPACITY, OP_ENQUEUE, 32'd0,         1'b0, NO_RESULT},
        '{ROW_REQUEST,  OP_ENQUEUE, 32'h5A5A_5A5A, 1'b1, '{ST_DONE,  32'h0000_0000, 1'b1, 1'b0}},
        '{ROW_REQUEST,  OP_ENQUEUE, 32'hA5A5_A5A5, 1'b1, '{ST_FULL,  32'h0000_0000, 1'b1, 1'b0}},
        '{ROW_CAPACITY, OP_ENQUEUE, 32'd15,        1'b0, NO_RESULT},
        '{ROW_REQUEST,  OP_ENQUEUE, 32'h0000_0001, 1'b0, NO_RESULT},
        '{ROW_REQUEST,  OP_ENQUEUE, 32'h0000_0002, 1'b0, NO_RESULT},
        '{ROW_REQUEST,  OP_ENQUEUE, 32'h1234_5678, 1'b0, NO_RESULT},
        '{ROW_REQUEST,  OP_ENQUEUE, 32'hDEAD_BEEF, 1'b0, NO_RESULT},
        '{ROW_REQUEST,  OP_ENQUEUE, 32'h0F0F_0F0F, 1'b0, NO_RESULT},
        '{ROW_REQUEST,  OP_ENQUEUE, 32'hF0F0_F0F0, 1'b0, NO_RESULT},
        // shrink while seven words are held: tail sits past the new wrap point
        '{ROW_CAPACITY, OP_ENQUEUE, 32'd3,         1'b0, NO_RESULT},
        '{ROW_REQUEST,  OP_ENQUEUE, 32'h1111_1111, 1'b0, NO_RESULT},
        '{ROW_REQUEST,  OP_DEQUEUE, 32'h0000_0000, 1'b0, NO_RESULT},
        '{ROW_REQUEST,  OP_ENQUEUE, 32'h2222_2222, 1'b0, NO_RESULT},
        '{ROW_REQUEST,  OP_DEQUEUE, 32'h0000_0000, 1'b0, NO_RESULT},
        '{ROW_REQUEST,  OP_DEQUEUE, 32'h0000_0000, 1'b0, NO_RESULT},
        '{ROW_REQUEST,  OP_DEQUEUE, 32'h0000_0000, 1'b0, NO_RESULT},
        '{ROW_CAPACITY, OP_ENQUEUE, 32'd8,         1'b0, NO_RESULT}
    };

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    circular_fifo_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the queue
    logic [31:0] ring_words [DEPTH];
    logic        word_written [DEPTH];
    logic [2:0]  rd_ptr;
    logic [2:0]  wr_ptr;
    logic        ring_is_empty;
    logic [3:0]  capacity_reg;

    out_item_t pending_results [$];
    int error_count   = 0;
    int requests_sent = 0;
    int results_taken = 0;
    int hold_cycles   = 0;
    bit hold_done     = 1'b0;

    function automatic logic [3:0] wrap_capacity();
        if (capacity_reg == 4'd0) return 4'd1;
        if (capacity_reg > DEPTH) return 4'(DEPTH);
        return capacity_reg;
    endfunction

    function automatic logic [2:0] next_ptr(logic [2:0] p);
        return ({1'b0, p} >= wrap_capacity() - 4'd1) ? 3'd0 : p + 3'd1;
    endfunction

    function automatic logic ring_full();
        return !ring_is_empty && next_ptr(wr_ptr) == rd_ptr;
    endfunction

    function automatic out_item_t fifo_predict(op_t op, logic [31:0] word);
        out_item_t r;
        r.status    = ST_DONE;
        r.pop_value = '0;
        if (op == OP_ENQUEUE) begin
            if (ring_full()) begin
                r.status = ST_FULL;
            end else begin
                if (ring_is_empty) begin
                    rd_ptr        = 3'd0;
                    wr_ptr        = 3'd0;
                    ring_is_empty = 1'b0;
                end else begin
                    wr_ptr = next_ptr(wr_ptr);
                end
                ring_words[wr_ptr]   = word;
                word_written[wr_ptr] = 1'b1;
            end
        end else if (ring_is_empty) begin
            r.status    = ST_EMPTY;
            r.pop_value = '1;
        end else begin
            r.pop_value = ring_words[rd_ptr];
            if (rd_ptr == wr_ptr) begin
                rd_ptr        = 3'd0;
                wr_ptr        = 3'd0;
                ring_is_empty = 1'b1;
            end else begin
                rd_ptr = next_ptr(rd_ptr);
            end
        end
        r.is_full  = ring_full();
        r.is_empty = ring_is_empty;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            error_count++;
            // keep the log short on a badly broken block
            if (error_count <= 40) $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
        end
    endfunction

    function automatic void check_result(out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 40) $error("unexpected result: 0x%h", got);
            return;
        end
        want = pending_results.pop_front();
        check_field("status",    32'(want.status),    32'(got.status));
        check_field("pop_value", want.pop_value,      got.pop_value);
        check_field("is_full",   32'(want.is_full),   32'(got.is_full));
        check_field("is_empty",  32'(want.is_empty),  32'(got.is_empty));
    endfunction

    task automatic send_request(input op_t op, input logic [31:0] word,
                                input logic typed, input out_item_t want);
        in_item_t  item;
        out_item_t predicted;
        item.func       = op;
        item.push_value = word;
        if (!(requests_sent >= 400 && requests_sent < 650) && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        predicted = fifo_predict(op, word);
        pending_results.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        capacity_reg = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Receiver: random stalls, one long hold-off, and a band with no stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
                results_taken++;
            end
            if (hold_cycles != 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else if (results_taken >= HOLD_AT && !hold_done) begin
                hold_done   = 1'b1;
                hold_cycles = HOLD_LEN;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (results_taken >= 500 && results_taken < 750)
                           || ($urandom_range(99) >= 6);
            end
        end
    end

    initial begin
        op_t         op;
        int          enq_pct;
        int          run_len;
        logic [3:0]  cap;

        for (int i = 0; i < DEPTH; i++) begin
            ring_words[i]   = '0;
            word_written[i] = 1'b0;
        end
        rd_ptr        = 3'd0;
        wr_ptr        = 3'd0;
        ring_is_empty = 1'b1;
        capacity_reg  = 4'(CAP_RESET);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (DIRECTED[i].kind == ROW_CAPACITY) begin
                wait_idle();
                write_capacity(DIRECTED[i].word[3:0]);
            end else begin
                send_request(DIRECTED[i].op, DIRECTED[i].word, DIRECTED[i].typed,
                             DIRECTED[i].want);
            end
        end

        while (requests_sent < REQUEST_GOAL) begin
            wait_idle();
            case ($urandom_range(0, 7))
                0:       cap = 4'd0;
                1:       cap = 4'd1;
                2:       cap = 4'(DEPTH);
                3:       cap = 4'd15;
                default: cap = 4'($urandom_range(0, 15));
            endcase
            write_capacity(cap);
            case ($urandom_range(0, 3))
                0:       enq_pct = 25;
                1:       enq_pct = 75;
                default: enq_pct = 50;
            endcase
            run_len = $urandom_range(30, 90);
            repeat (run_len) begin
                op = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
                // never pop a slot that has not been written since the start of the test
                if (op == OP_DEQUEUE && !ring_is_empty && !word_written[rd_ptr])
                    op = OP_ENQUEUE;
                send_request(op, $urandom, 1'b0, NO_RESULT);
            end
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
